FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the ray box entry RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RBSE_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define RBSE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBSE_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg)
`define RBSE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/rbse_pkg.sv
// ----------------------------------------------------------------------------
// rbse_pkg
// Shared types and constants of the ray box entry block.
// ----------------------------------------------------------------------------
package rbse_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_FACES = 6;
  localparam int FACE_W    = 3;
  localparam int CFG_IDX_W = 3;

  // Face codes: low and high face per axis.
  typedef enum logic [FACE_W-1:0] {
    FACE_LOW_X,
    FACE_HIGH_X,
    FACE_LOW_Y,
    FACE_HIGH_Y,
    FACE_LOW_Z,
    FACE_HIGH_Z
  } face_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_LOW_X,
    CFG_BOX_LOW_Y,
    CFG_BOX_LOW_Z,
    CFG_BOX_HIGH_X,
    CFG_BOX_HIGH_Y,
    CFG_BOX_HIGH_Z
  } cfg_reg_t;

  // Outcome of the face selection stage.
  typedef struct packed {
    logic  found;
    logic  two_dist;
    face_t face;
  } pick_ctl_t;

endpackage

FILE: hw/rtl/rbse_delay.sv
// ----------------------------------------------------------------------------
// rbse_delay
// Fixed-length register delay line for payload that rides along the pipeline.
// ----------------------------------------------------------------------------
module rbse_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] stage_r [DEPTH];

  // Shift one stage per clock.
  always_ff @(posedge clk) begin
    stage_r[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      stage_r[k] <= stage_r[k-1];
    end
  end

  assign d_o = stage_r[DEPTH-1];

endmodule

FILE: hw/rtl/rbse_face_time.sv
// ----------------------------------------------------------------------------
// rbse_face_time
// Hit time of one face plane: floor((bound - pos) * 2^FB / dir), saturated.
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module rbse_face_time #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] bound_i,
  input  logic signed [CW-1:0] pos_i,
  input  logic signed [CW-1:0] dir_i,
  output logic signed [CW-1:0] t_o,
  output logic                 dnz_o
);

  localparam int NQ = CW + FB + 1;

  // Operand preparation.
  logic signed [CW:0]   diff;
  logic        [NQ-1:0] num_u;
  logic        [NQ-1:0] num_mag;
  logic        [CW-1:0] dir_u;
  logic        [CW-1:0] den_mag;

  always_comb begin
    diff    = {bound_i[CW-1], bound_i} - {pos_i[CW-1], pos_i};
    num_u   = {diff, {FB{1'b0}}};
    num_mag = num_u[NQ-1] ? (~num_u + 1'b1) : num_u;
    dir_u   = dir_i;
    den_mag = dir_u[CW-1] ? (~dir_u + 1'b1) : dir_u;
  end

  // Divider stage registers; index 0 is the operand register.
  logic [CW-1:0] rem_r  [NQ+1];
  logic [NQ-1:0] work_r [NQ+1];
  logic [CW-1:0] den_r  [NQ+1];
  logic          neg_r  [NQ+1];
  logic          dnz_r  [NQ+1];

  always_ff @(posedge clk) begin
    logic [CW:0] trial;
    logic [CW:0] sub;
    logic        ge;
    rem_r[0]  <= '0;
    work_r[0] <= num_mag;
    den_r[0]  <= den_mag;
    neg_r[0]  <= num_u[NQ-1] ^ dir_i[CW-1];
    dnz_r[0]  <= |dir_i;
    for (int k = 0; k < NQ; k++) begin
      trial = {rem_r[k], work_r[k][NQ-1]};
      sub   = trial - {1'b0, den_r[k]};
      ge    = trial >= {1'b0, den_r[k]};
      rem_r[k+1]  <= ge ? sub[CW-1:0] : trial[CW-1:0];
      work_r[k+1] <= {work_r[k][NQ-2:0], ge};
      den_r[k+1]  <= den_r[k];
      neg_r[k+1]  <= neg_r[k];
      dnz_r[k+1]  <= dnz_r[k];
    end
  end

  // Apply sign with floor rounding, then saturate to the coordinate range.
  localparam logic signed [NQ:0] SMAX = {{(NQ-CW+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NQ:0] SMIN = {{(NQ-CW+2){1'b1}}, {(CW-1){1'b0}}};

  logic        [NQ:0]   q_ext;
  logic signed [NQ:0]   q_s;
  logic signed [CW-1:0] t_nxt;

  always_comb begin
    q_ext = {1'b0, work_r[NQ]};
    if (neg_r[NQ]) begin
      q_s = $signed((~q_ext + 1'b1) - {{NQ{1'b0}}, |rem_r[NQ]});
    end else begin
      q_s = $signed(q_ext);
    end
    if (q_s > SMAX) begin
      t_nxt = {1'b0, {(CW-1){1'b1}}};
    end else if (q_s < SMIN) begin
      t_nxt = {1'b1, {(CW-1){1'b0}}};
    end else begin
      t_nxt = q_s[CW-1:0];
    end
  end

  logic signed [CW-1:0] t_r;
  logic                 dnz_out_r;

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    dnz_out_r <= dnz_r[NQ];
  end

  assign t_o   = t_r;
  assign dnz_o = dnz_out_r;

endmodule

FILE: hw/rtl/rbse_advance.sv
// ----------------------------------------------------------------------------
// rbse_advance
// Moves one coordinate along the ray: pos + floor(t * dir / 2^FB), saturated.
// Two stages: multiply, then shift, add and saturate.
// ----------------------------------------------------------------------------
module rbse_advance #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] pos_i,
  input  logic signed [CW-1:0] t_i,
  input  logic signed [CW-1:0] dir_i,
  output logic signed [CW-1:0] res_o
);

  localparam logic signed [2*CW:0] SMAX = {{(CW+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [2*CW:0] SMIN = {{(CW+2){1'b1}}, {(CW-1){1'b0}}};

  logic signed [2*CW-1:0] prod_r;
  logic signed [CW-1:0]   pos_r;

  // Product stage.
  always_ff @(posedge clk) begin
    prod_r <= t_i * dir_i;
    pos_r  <= pos_i;
  end

  // Arithmetic shift gives the floor; then add and clamp.
  logic signed [2*CW-1:0] sh;
  logic signed [2*CW:0]   sum;
  logic signed [CW-1:0]   res_nxt;

  always_comb begin
    sh  = prod_r >>> FB;
    sum = $signed({{(CW+1){pos_r[CW-1]}}, pos_r}) + $signed({sh[2*CW-1], sh});
    if (sum > SMAX) begin
      res_nxt = {1'b0, {(CW-1){1'b1}}};
    end else if (sum < SMIN) begin
      res_nxt = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res_nxt = sum[CW-1:0];
    end
  end

  logic signed [CW-1:0] res_r;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

FILE: hw/rtl/rbse_pick.sv
// ----------------------------------------------------------------------------
// rbse_pick
// Picks the earliest valid face (lowest index on ties), counts distinct
// times and forms the midpoint time of the earliest and one other distinct hit.
// ----------------------------------------------------------------------------
module rbse_pick import rbse_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] t_i  [NUM_FACES],
  input  logic [NUM_FACES-1:0] ok_i,
  input  logic signed [CW-1:0] pt_i [NUM_FACES][NUM_AXES],
  output pick_ctl_t            ctl_o,
  output logic signed [CW-1:0] mid_o,
  output logic signed [CW-1:0] pt_o [NUM_AXES]
);

  logic [NUM_FACES-1:0] lt [NUM_FACES];
  logic [NUM_FACES-1:0] eq [NUM_FACES];
  logic [NUM_FACES-1:0] best_oh;
  logic [NUM_FACES-1:0] first_oh;
  logic [NUM_FACES-1:0] other_oh;
  logic signed [CW-1:0] t_best;
  logic signed [CW-1:0] t_other;
  logic signed [CW:0]   t_sum;
  pick_ctl_t            ctl_nxt;
  logic signed [CW-1:0] pt_nxt [NUM_AXES];

  // Pairwise comparisons, all in parallel.
  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int g = 0; g < NUM_FACES; g++) begin
        lt[f][g] = t_i[f] < t_i[g];
        eq[f][g] = t_i[f] == t_i[g];
      end
    end
  end

  // Winner and distinct representatives from the comparison matrix.
  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      best_oh[f]  = ok_i[f];
      first_oh[f] = ok_i[f];
      for (int g = 0; g < NUM_FACES; g++) begin
        if (g < f && ok_i[g] && !lt[f][g]) begin
          best_oh[f] = 1'b0;
        end
        if (g > f && ok_i[g] && lt[g][f]) begin
          best_oh[f] = 1'b0;
        end
        if (g < f && ok_i[g] && eq[g][f]) begin
          first_oh[f] = 1'b0;
        end
      end
    end
    other_oh = first_oh & ~best_oh;
  end

  // Select times, face code and point of the winner.
  always_comb begin
    t_best  = '0;
    t_other = '0;
    ctl_nxt.face = FACE_LOW_X;
    for (int a = 0; a < NUM_AXES; a++) begin
      pt_nxt[a] = '0;
    end
    for (int f = 0; f < NUM_FACES; f++) begin
      if (best_oh[f]) begin
        t_best       = t_i[f];
        ctl_nxt.face = face_t'(f[FACE_W-1:0]);
        for (int a = 0; a < NUM_AXES; a++) begin
          pt_nxt[a] = pt_i[f][a];
        end
      end
      if (other_oh[f]) begin
        t_other = t_i[f];
      end
    end
    ctl_nxt.found    = |ok_i;
    ctl_nxt.two_dist = $countones(first_oh) == 2;
    // Both times are non-negative here, so halving is a plain shift.
    t_sum = {t_best[CW-1], t_best} + {t_other[CW-1], t_other};
  end

  logic signed [CW-1:0] mid_r;
  pick_ctl_t            ctl_r;
  logic signed [CW-1:0] pt_r [NUM_AXES];

  always_ff @(posedge clk) begin
    ctl_r <= ctl_nxt;
    mid_r <= t_sum[CW:1];
    for (int a = 0; a < NUM_AXES; a++) begin
      pt_r[a] <= pt_nxt[a];
    end
  end

  assign ctl_o = ctl_r;
  assign mid_o = mid_r;
  assign pt_o  = pt_r;

endmodule

FILE: hw/rtl/ray_box_surface_entry_core.sv
// ----------------------------------------------------------------------------
// ray_box_surface_entry_core
// Moves a point along a ray onto the first face of a configured box.
// ----------------------------------------------------------------------------
// Usage:
//   A ray beat (point and direction, fixed point with FRAC_BITS fraction
//   bits) is taken on a rising edge with start high and busy low. busy is
//   high during reset and for the cycle that follows it; after that a ray
//   can be taken on every clock.
//   Each ray gives exactly one result beat: out_strobe is high for one cycle
//   with out_hit, out_face and out_x/y/z. The pipeline depth is set mainly
//   by the face-time divider, which resolves one quotient bit per stage;
//   six of them run side by side. Throughput is one ray per cycle.
//   Results cannot be held off, so there is no back-pressure anywhere
//   in the pipeline.
//   The six box registers are written through cfg_valid/cfg_index/cfg_data
//   (cfg_ready is always high; indexes above the high z corner are ignored).
//   Write them only while no ray is in flight; the block does not enforce it.
//   Reset (rst_n low, synchronous) clears the box to zero and drops every ray
//   in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_box_surface_entry_core import rbse_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Ray channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  // Result channel
  output logic                          out_strobe,
  output logic                          out_hit,
  output logic [FACE_W-1:0]             out_face,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  // Configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int LT  = CW + FB + 3;   // face-time latency
  localparam int LAT = LT + 7;        // stage index of the output register
  localparam int AW  = 6 * CW + 1;    // point, direction and inside flag
  localparam int TW  = CW + 1;        // time with direction-nonzero flag
  localparam int FW  = $bits(pick_ctl_t) + 6 * CW + 1;

  // Box registers and configuration writes.
  logic signed [CW-1:0] box_low_r  [NUM_AXES];
  logic signed [CW-1:0] box_high_r [NUM_AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_low_r[a]  <= '0;
        box_high_r[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BOX_LOW_X:  box_low_r[0]  <= cfg_data;
        CFG_BOX_LOW_Y:  box_low_r[1]  <= cfg_data;
        CFG_BOX_LOW_Z:  box_low_r[2]  <= cfg_data;
        CFG_BOX_HIGH_X: box_high_r[0] <= cfg_data;
        CFG_BOX_HIGH_Y: box_high_r[1] <= cfg_data;
        CFG_BOX_HIGH_Z: box_high_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and valid chain.
  logic           busy_r;
  logic           accept;
  logic [LAT:0]   vld_r;

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LAT-1:0], accept};
    end
  end

  // Stage 0: input register and start-inside test.
  logic signed [CW-1:0] pos0_r [NUM_AXES];
  logic signed [CW-1:0] dir0_r [NUM_AXES];
  logic                 inside0;
  logic [AW-1:0]        a0;

  always_ff @(posedge clk) begin
    pos0_r[0] <= in_pos_x;
    pos0_r[1] <= in_pos_y;
    pos0_r[2] <= in_pos_z;
    dir0_r[0] <= in_dir_x;
    dir0_r[1] <= in_dir_y;
    dir0_r[2] <= in_dir_z;
  end

  always_comb begin
    inside0 = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (pos0_r[a] < box_low_r[a] || pos0_r[a] > box_high_r[a]) begin
        inside0 = 1'b0;
      end
      a0[a*CW +: CW]     = pos0_r[a];
      a0[(3+a)*CW +: CW] = dir0_r[a];
    end
    a0[AW-1] = inside0;
  end

  // Face times, one divider pipeline per face.
  logic signed [CW-1:0] bound_w [NUM_FACES];
  logic signed [CW-1:0] t_lt    [NUM_FACES];
  logic                 dnz_lt  [NUM_FACES];

  // Ray payload aligned with the face times.
  logic [AW-1:0]        a1;
  logic signed [CW-1:0] pos1 [NUM_AXES];
  logic signed [CW-1:0] dir1 [NUM_AXES];

  rbse_delay #(.WIDTH(AW), .DEPTH(LT)) u_dly_ray1 (
    .clk (clk),
    .d_i (a0),
    .d_o (a1)
  );

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pos1[a] = a1[a*CW +: CW];
      dir1[a] = a1[(3+a)*CW +: CW];
    end
  end

  // Face points on the other two axes; the own axis sits on the bound.
  logic signed [CW-1:0] pt2 [NUM_FACES][NUM_AXES];

  for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
    localparam int AX = f >> 1;
    localparam int HI = f & 1;

    assign bound_w[f] = (HI != 0) ? box_high_r[AX] : box_low_r[AX];

    rbse_face_time #(.CW(CW), .FB(FB)) u_time (
      .clk     (clk),
      .bound_i (bound_w[f]),
      .pos_i   (pos0_r[AX]),
      .dir_i   (dir0_r[AX]),
      .t_o     (t_lt[f]),
      .dnz_o   (dnz_lt[f])
    );

    for (genvar b = 0; b < NUM_AXES; b++) begin : g_axis
      if (b == AX) begin : g_own
        assign pt2[f][b] = bound_w[f];
      end else begin : g_other
        rbse_advance #(.CW(CW), .FB(FB)) u_adv (
          .clk   (clk),
          .pos_i (pos1[b]),
          .t_i   (t_lt[f]),
          .dir_i (dir1[b]),
          .res_o (pt2[f][b])
        );
      end
    end
  end

  // Times aligned with the face points.
  logic [NUM_FACES*TW-1:0] tv1;
  logic [NUM_FACES*TW-1:0] tv2;
  logic signed [CW-1:0]    t2   [NUM_FACES];
  logic                    dnz2 [NUM_FACES];

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      tv1[f*TW +: TW] = {dnz_lt[f], t_lt[f]};
      t2[f]           = tv2[f*TW +: CW];
      dnz2[f]         = tv2[f*TW + CW];
    end
  end

  rbse_delay #(.WIDTH(NUM_FACES*TW), .DEPTH(2)) u_dly_time (
    .clk (clk),
    .d_i (tv1),
    .d_o (tv2)
  );

  // Face qualification: nonzero direction, time not negative, hit on face.
  logic [NUM_FACES-1:0] ok2;

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      ok2[f] = dnz2[f] && !t2[f][CW-1];
      for (int b = 0; b < NUM_AXES; b++) begin
        if (b != (f >> 1) &&
            (pt2[f][b] < box_low_r[b] || pt2[f][b] > box_high_r[b])) begin
          ok2[f] = 1'b0;
        end
      end
    end
  end

  logic [NUM_FACES-1:0] ok3_r;
  logic signed [CW-1:0] t3_r  [NUM_FACES];
  logic signed [CW-1:0] pt3_r [NUM_FACES][NUM_AXES];

  always_ff @(posedge clk) begin
    ok3_r <= ok2;
    t3_r  <= t2;
    pt3_r <= pt2;
  end

  // Face selection and midpoint time.
  pick_ctl_t            ctl4;
  logic signed [CW-1:0] mid4;
  logic signed [CW-1:0] ptsel4 [NUM_AXES];

  rbse_pick #(.CW(CW)) u_pick (
    .clk   (clk),
    .t_i   (t3_r),
    .ok_i  (ok3_r),
    .pt_i  (pt3_r),
    .ctl_o (ctl4),
    .mid_o (mid4),
    .pt_o  (ptsel4)
  );

  // Ray payload aligned with the selection.
  logic [AW-1:0]        a4;
  logic signed [CW-1:0] pos4 [NUM_AXES];
  logic signed [CW-1:0] dir4 [NUM_AXES];
  logic                 inside4;

  rbse_delay #(.WIDTH(AW), .DEPTH(4)) u_dly_ray4 (
    .clk (clk),
    .d_i (a1),
    .d_o (a4)
  );

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pos4[a] = a4[a*CW +: CW];
      dir4[a] = a4[(3+a)*CW +: CW];
    end
    inside4 = a4[AW-1];
  end

  // Midpoint of the two hits, for the grazing test.
  logic signed [CW-1:0] m6 [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_mid
    rbse_advance #(.CW(CW), .FB(FB)) u_adv_mid (
      .clk   (clk),
      .pos_i (pos4[a]),
      .t_i   (mid4),
      .dir_i (dir4[a]),
      .res_o (m6[a])
    );
  end

  // Selection outcome aligned with the midpoint.
  logic [FW-1:0]        f4;
  logic [FW-1:0]        f6;
  pick_ctl_t            ctl6;
  logic signed [CW-1:0] ptsel6 [NUM_AXES];
  logic signed [CW-1:0] pos6   [NUM_AXES];
  logic                 inside6;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      f4[a*CW +: CW]     = ptsel4[a];
      f4[(3+a)*CW +: CW] = pos4[a];
      ptsel6[a]          = f6[a*CW +: CW];
      pos6[a]            = f6[(3+a)*CW +: CW];
    end
    f4[6*CW]                           = inside4;
    f4[FW-1 -: $bits(pick_ctl_t)]      = ctl4;
    inside6                            = f6[6*CW];
    ctl6 = pick_ctl_t'(f6[FW-1 -: $bits(pick_ctl_t)]);
  end

  rbse_delay #(.WIDTH(FW), .DEPTH(2)) u_dly_pick (
    .clk (clk),
    .d_i (f4),
    .d_o (f6)
  );

  // Final decision: inside start, or exactly two times and a strict midpoint.
  logic                 strict6;
  logic                 hit_nxt;
  logic [FACE_W-1:0]    face_nxt;
  logic signed [CW-1:0] res_nxt [NUM_AXES];

  always_comb begin
    strict6 = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (m6[a] <= box_low_r[a] || m6[a] >= box_high_r[a]) begin
        strict6 = 1'b0;
      end
    end
    hit_nxt  = ctl6.found && (inside6 || (ctl6.two_dist && strict6));
    face_nxt = hit_nxt ? ctl6.face : FACE_LOW_X;
    for (int a = 0; a < NUM_AXES; a++) begin
      res_nxt[a] = hit_nxt ? ptsel6[a] : pos6[a];
    end
  end

  // Output register.
  logic                 out_hit_r;
  logic [FACE_W-1:0]    out_face_r;
  logic signed [CW-1:0] out_res_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_hit_r <= 1'b0;
    end else begin
      out_hit_r <= vld_r[LAT-1] && hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_face_r <= face_nxt;
    out_res_r  <= res_nxt;
  end

  assign out_strobe = vld_r[LAT];
  assign out_hit    = out_hit_r;
  assign out_face   = out_face_r;
  assign out_x      = out_res_r[0];
  assign out_y      = out_res_r[1];
  assign out_z      = out_res_r[2];

  // Checks on the result beat and the start-up handshake.
  `RBSE_ASSERT_IMPL(a_hit_has_strobe, clk, rst_n, out_hit, out_strobe, "hit without strobe")
  `RBSE_ASSERT_IMPL(a_face_range, clk, rst_n, out_strobe, out_face <= FACE_HIGH_Z, "bad face")
  `RBSE_ASSERT_IMPL(a_miss_face, clk, rst_n, out_strobe && !out_hit, out_face == FACE_LOW_X, "miss face")
  `RBSE_ASSERT_NEXT(a_busy_release, clk, rst_n, rst_n, !busy, "busy after reset")

endmodule
